### src/vad_pkg.sv
// shared constants, types and the arctangent table for the vector angle core
package vad_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 24;
  localparam int PRESCALE   = 30;
  localparam int STEPS      = 26;
  localparam int STEP_W     = $clog2(STEPS);

  // x grows by the cordic gain and the sqrt2 of the fold, three guard bits cover both
  localparam int XY_W  = COORD_BITS + PRESCALE + 3;
  localparam int Z_W   = 32;
  localparam int OCT_W = FRAC_BITS + 6;
  localparam int SUM_W = FRAC_BITS + 10;
  localparam int DEG_W = 10;

  localparam int IN_BITS   = 4 * COORD_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int IN_DATA_W = IN_BYTES * 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [OCT_W-1:0] OCT_MAX = OCT_W'(45) << FRAC_BITS;
  localparam logic [SUM_W-1:0] DEG_90  = SUM_W'(90) << FRAC_BITS;
  localparam logic [SUM_W-1:0] DEG_180 = SUM_W'(180) << FRAC_BITS;
  localparam logic [SUM_W-1:0] DEG_270 = SUM_W'(270) << FRAC_BITS;

  // atan(2^-i) in degrees, q8.24
  localparam logic [Z_W-1:0] ATAN_TAB [STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
    32'd29
  };

  typedef struct packed {
    logic is_zero;   // point equals center
    logic on_axis;   // smaller magnitude is zero
    logic diag;      // magnitudes equal
    logic swap;      // |dy| > |dx|, octant angle measured from the y axis
    logic neg_dx;
    logic neg_dy;
  } ctl_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

endpackage

### src/vad_prep.sv
// input stage: differences, absolute values and fold into the first octant
module vad_prep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [vad_pkg::COORD_BITS-1:0]       point_x,
  input  logic [vad_pkg::COORD_BITS-1:0]       point_y,
  input  logic [vad_pkg::COORD_BITS-1:0]       center_x,
  input  logic [vad_pkg::COORD_BITS-1:0]       center_y,
  output logic                                 out_valid,
  output vad_pkg::ctl_t                        out_ctl,
  output vad_pkg::rot_t                        out_rot
);
  import vad_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic [COORD_BITS-1:0]      big;
  logic [COORD_BITS-1:0]      sml;
  logic                       swap;
  ctl_t                       ctl_next;
  rot_t                       rot_next;

  always_comb begin
    dx   = $signed({1'b0, point_x}) - $signed({1'b0, center_x});
    dy   = $signed({1'b0, center_y}) - $signed({1'b0, point_y});
    ax   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    swap = ay > ax;
    big  = swap ? ay : ax;
    sml  = swap ? ax : ay;

    ctl_next.is_zero = (ax == '0) && (ay == '0);
    ctl_next.on_axis = (sml == '0);
    ctl_next.diag    = (sml == big);
    ctl_next.swap    = swap;
    ctl_next.neg_dx  = dx[COORD_BITS];
    ctl_next.neg_dy  = dy[COORD_BITS];

    rot_next.x = $signed({3'b000, big, {PRESCALE{1'b0}}});
    rot_next.y = $signed({3'b000, sml, {PRESCALE{1'b0}}});
    rot_next.z = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl <= ctl_next;
      out_rot <= rot_next;
    end
  end

endmodule

### src/vad_cordic_stage.sv
// one registered cordic vectoring micro-rotation
module vad_cordic_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [vad_pkg::STEP_W-1:0]  step,
  input  logic                        in_valid,
  input  vad_pkg::ctl_t               in_ctl,
  input  vad_pkg::rot_t               in_rot,
  output logic                        out_valid,
  output vad_pkg::ctl_t               out_ctl,
  output vad_pkg::rot_t               out_rot
);
  import vad_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  ang;
  rot_t                   rot_next;

  always_comb begin
    xs  = in_rot.x >>> step;
    ys  = in_rot.y >>> step;
    ang = $signed(ATAN_TAB[step]);
    if (!in_rot.y[XY_W-1]) begin
      rot_next.x = in_rot.x + ys;
      rot_next.y = in_rot.y - xs;
      rot_next.z = in_rot.z + ang;
    end else begin
      rot_next.x = in_rot.x - ys;
      rot_next.y = in_rot.y + xs;
      rot_next.z = in_rot.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl <= in_ctl;
      out_rot <= rot_next;
    end
  end

endmodule

### src/vad_unfold.sv
// output stages: clamp the octant angle, unfold to the full circle, truncate to degrees
module vad_unfold (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  vad_pkg::ctl_t                     in_ctl,
  input  logic signed [vad_pkg::Z_W-1:0]    in_z,
  output logic                              out_valid,
  output logic signed [vad_pkg::DEG_W-1:0]  out_deg
);
  import vad_pkg::*;

  logic             mid_valid;
  ctl_t             mid_ctl;
  logic [OCT_W-1:0] oct;
  logic [OCT_W-1:0] oct_next;

  logic [SUM_W-1:0]  base;
  logic              sub;
  logic [SUM_W-1:0]  oct_ext;
  logic [SUM_W-1:0]  sum;
  logic [DEG_W-1:0]  whole;
  logic [DEG_W-1:0]  deg_next;

  always_comb begin
    priority if (in_ctl.on_axis) begin
      oct_next = '0;
    end else if (in_ctl.diag) begin
      oct_next = OCT_MAX;
    end else if (in_z[Z_W-1]) begin
      oct_next = '0;
    end else if (in_z > $signed({{(Z_W-OCT_W){1'b0}}, OCT_MAX})) begin
      oct_next = OCT_MAX;
    end else begin
      oct_next = in_z[OCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_ctl <= in_ctl;
      oct     <= oct_next;
    end
  end

  // lower half plane right of the y axis reuses the first-quadrant sum and negates the degrees
  always_comb begin
    oct_ext = SUM_W'(oct);
    unique case ({mid_ctl.neg_dx, mid_ctl.neg_dy})
      2'b10: begin
        base = mid_ctl.swap ? DEG_90 : DEG_180;
        sub  = !mid_ctl.swap;
      end
      2'b11: begin
        base = mid_ctl.swap ? DEG_270 : DEG_180;
        sub  = mid_ctl.swap;
      end
      default: begin
        base = mid_ctl.swap ? DEG_90 : '0;
        sub  = mid_ctl.swap;
      end
    endcase
    sum   = sub ? base - oct_ext : base + oct_ext;
    whole = sum[FRAC_BITS +: DEG_W];
    if (mid_ctl.is_zero) begin
      deg_next = '0;
    end else if (!mid_ctl.neg_dx && mid_ctl.neg_dy) begin
      deg_next = -whole;
    end else begin
      deg_next = whole;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_deg <= $signed(deg_next);
    end
  end

endmodule

### src/vector_angle_degrees_core.sv
// direction angle in whole degrees of a point about a center, pipelined cordic
// pipeline stages from input transaction to result: 1 fold, 26 cordic, 2 unfold
// throughput: one transaction per cycle while the output is not stalled; the 26 unrolled cordic stages set the depth
// the whole pipeline holds while the output register is full and not taken
// reset: synchronous active-high rst clears all stage valid bits
module vector_angle_degrees_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // point_x, point_y, center_x, center_y from the lowest bit up
  input  logic [vad_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // angle_degrees (signed) in the low bits, zero above
  output logic [vad_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import vad_pkg::*;

  logic en;

  logic valid_s [STEPS+1];
  ctl_t ctl_s   [STEPS+1];
  rot_t rot_s   [STEPS+1];

  logic                    out_valid;
  logic signed [DEG_W-1:0] out_deg;

  assign en       = m_tready || !out_valid;
  assign s_tready = en;

  vad_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .point_x  (s_tdata[0*COORD_BITS +: COORD_BITS]),
    .point_y  (s_tdata[1*COORD_BITS +: COORD_BITS]),
    .center_x (s_tdata[2*COORD_BITS +: COORD_BITS]),
    .center_y (s_tdata[3*COORD_BITS +: COORD_BITS]),
    .out_valid(valid_s[0]),
    .out_ctl  (ctl_s[0]),
    .out_rot  (rot_s[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    vad_cordic_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .step     (STEP_W'(i)),
      .in_valid (valid_s[i]),
      .in_ctl   (ctl_s[i]),
      .in_rot   (rot_s[i]),
      .out_valid(valid_s[i+1]),
      .out_ctl  (ctl_s[i+1]),
      .out_rot  (rot_s[i+1])
    );
  end

  vad_unfold u_unfold (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (valid_s[STEPS]),
    .in_ctl   (ctl_s[STEPS]),
    .in_z     (rot_s[STEPS].z),
    .out_valid(out_valid),
    .out_deg  (out_deg)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-DEG_W){1'b0}}, out_deg};

endmodule
